// File: design/stim_pkg.sv
// ----------------------------------------------------------------------------
// stim_pkg
// Shared types and constants of the strided tensor index mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package stim_pkg;

  localparam int unsigned IDX_W    = 48;  // linear index width
  localparam int unsigned SIDX_W   = 42;  // storage index width
  localparam int unsigned SIZE_W   = 16;
  localparam int unsigned STRIDE_W = 24;
  localparam int unsigned BASE_W   = 32;
  localparam int unsigned PROD_W   = SIZE_W + STRIDE_W;
  localparam int unsigned CFG_AW   = 5;
  localparam int unsigned CFG_DW   = 32;

  // quotient bits resolved per divider stage
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = IDX_W / DIV_STEPS;

  // register indexes
  localparam logic [2:0] REG_SIZE_OUTER    = 3'd0;
  localparam logic [2:0] REG_SIZE_MIDDLE   = 3'd1;
  localparam logic [2:0] REG_SIZE_INNER    = 3'd2;
  localparam logic [2:0] REG_STRIDE_OUTER  = 3'd3;
  localparam logic [2:0] REG_STRIDE_MIDDLE = 3'd4;
  localparam logic [2:0] REG_STRIDE_INNER  = 3'd5;
  localparam logic [2:0] REG_BASE_OFFSET   = 3'd6;

  typedef struct packed {
    logic [SIZE_W-1:0]   size_outer;
    logic [SIZE_W-1:0]   size_middle;
    logic [SIZE_W-1:0]   size_inner;
    logic [STRIDE_W-1:0] stride_outer;
    logic [STRIDE_W-1:0] stride_middle;
    logic [STRIDE_W-1:0] stride_inner;
    logic [BASE_W-1:0]   base_offset;
  } stim_cfg_t;

  // one divider pipeline slot
  typedef struct packed {
    logic              vld;
    logic [SIZE_W-1:0] rem;
    logic [IDX_W-1:0]  run;
    logic [SIDX_W-1:0] acc;
  } stim_div_t;

  // one dimension's hand-off between stages
  typedef struct packed {
    logic              vld;
    logic [IDX_W-1:0]  run;
    logic [SIDX_W-1:0] acc;
  } stim_dim_t;

endpackage

`default_nettype wire

// File: design/stim_if.sv
// ----------------------------------------------------------------------------
// stim_if
// Valid/ready stream interfaces for linear and storage index transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface stim_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] linear_index;

  modport source (output valid, output linear_index, input ready);
  modport sink (input valid, input linear_index, output ready);
endinterface

interface stim_out_if;
  logic        valid;
  logic        ready;
  logic [41:0] storage_index;

  modport source (output valid, output storage_index, input ready);
  modport sink (input valid, input storage_index, output ready);
endinterface

`default_nettype wire

// File: design/stim_div_stage.sv
// ----------------------------------------------------------------------------
// stim_div_stage
// Restoring divider slice: resolves a few quotient bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module stim_div_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic [stim_pkg::SIZE_W-1:0] divisor,
  input  wire stim_pkg::stim_div_t         d_in,
  output stim_pkg::stim_div_t              d_out
);
  import stim_pkg::*;

  stim_div_t st_r;
  stim_div_t st_nxt;

  // shift one dividend bit into the remainder per step, quotient bit in at the bottom
  always_comb begin
    logic [SIZE_W:0] t;
    st_nxt = d_in;
    t      = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      t          = {st_nxt.rem, st_nxt.run[IDX_W-1]};
      st_nxt.run = {st_nxt.run[IDX_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t             = t - {1'b0, divisor};
        st_nxt.run[0] = 1'b1;
      end
      st_nxt.rem = t[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign d_out = st_r;

endmodule

`default_nettype wire

// File: design/stim_dim.sv
// ----------------------------------------------------------------------------
// stim_dim
// One tensor dimension: pipelined divide by size, coordinate times stride,
// accumulate into the storage index.
// ----------------------------------------------------------------------------
`default_nettype none

module stim_dim (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [stim_pkg::SIZE_W-1:0]   size,
  input  wire logic [stim_pkg::STRIDE_W-1:0] stride,
  input  wire stim_pkg::stim_dim_t           d_in,
  output stim_pkg::stim_dim_t                d_out
);
  import stim_pkg::*;

  logic [SIZE_W-1:0] divisor;
  stim_div_t         div_q [DIV_STAGES+1];

  logic              mul_vld_r;
  logic [PROD_W-1:0] mul_prod_r;
  logic [IDX_W-1:0]  mul_run_r;
  logic [SIDX_W-1:0] mul_acc_r;
  stim_dim_t         add_r;

  // size zero acts as size one
  assign divisor = (size == '0) ? SIZE_W'(1) : size;

  assign div_q[0] = '{vld: d_in.vld, rem: '0, run: d_in.run, acc: d_in.acc};

  // divider chain
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    stim_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .divisor (divisor),
      .d_in    (div_q[s]),
      .d_out   (div_q[s+1])
    );
  end

  // coordinate times stride
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else if (en) begin
      mul_vld_r  <= div_q[DIV_STAGES].vld;
      mul_prod_r <= div_q[DIV_STAGES].rem * stride;
      mul_run_r  <= div_q[DIV_STAGES].run;
      mul_acc_r  <= div_q[DIV_STAGES].acc;
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r.vld <= 1'b0;
    end else if (en) begin
      add_r.vld <= mul_vld_r;
      add_r.run <= mul_run_r;
      add_r.acc <= mul_acc_r + SIDX_W'(mul_prod_r);
    end
  end

  assign d_out = add_r;

endmodule

`default_nettype wire

// File: design/stim_cfg_regs.sv
// ----------------------------------------------------------------------------
// stim_cfg_regs
// APB-style register file holding sizes, strides and base offset.
// ----------------------------------------------------------------------------
`default_nettype none

module stim_cfg_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [stim_pkg::CFG_AW-1:0] paddr,
  input  wire logic [stim_pkg::CFG_DW-1:0] pwdata,
  output logic      [stim_pkg::CFG_DW-1:0] prdata,
  output logic                             pready,
  output stim_pkg::stim_cfg_t              cfg
);
  import stim_pkg::*;

  stim_cfg_t  cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_outer    <= SIZE_W'(1);
      cfg_r.size_middle   <= SIZE_W'(1);
      cfg_r.size_inner    <= SIZE_W'(1);
      cfg_r.stride_outer  <= '0;
      cfg_r.stride_middle <= '0;
      cfg_r.stride_inner  <= STRIDE_W'(1);
      cfg_r.base_offset   <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SIZE_OUTER:    cfg_r.size_outer    <= pwdata[SIZE_W-1:0];
        REG_SIZE_MIDDLE:   cfg_r.size_middle   <= pwdata[SIZE_W-1:0];
        REG_SIZE_INNER:    cfg_r.size_inner    <= pwdata[SIZE_W-1:0];
        REG_STRIDE_OUTER:  cfg_r.stride_outer  <= pwdata[STRIDE_W-1:0];
        REG_STRIDE_MIDDLE: cfg_r.stride_middle <= pwdata[STRIDE_W-1:0];
        REG_STRIDE_INNER:  cfg_r.stride_inner  <= pwdata[STRIDE_W-1:0];
        REG_BASE_OFFSET:   cfg_r.base_offset   <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_SIZE_OUTER:    prdata = CFG_DW'(cfg_r.size_outer);
      REG_SIZE_MIDDLE:   prdata = CFG_DW'(cfg_r.size_middle);
      REG_SIZE_INNER:    prdata = CFG_DW'(cfg_r.size_inner);
      REG_STRIDE_OUTER:  prdata = CFG_DW'(cfg_r.stride_outer);
      REG_STRIDE_MIDDLE: prdata = CFG_DW'(cfg_r.stride_middle);
      REG_STRIDE_INNER:  prdata = CFG_DW'(cfg_r.stride_inner);
      REG_BASE_OFFSET:   prdata = cfg_r.base_offset;
      default:           prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: design/strided_tensor_index_mapper_unit.sv
// Throughput: one transaction per cycle while the skid buffer is empty.
// Each dimension is a 12-stage divider
//   resolving 4 quotient bits per stage, then a multiply stage and an add stage.
// Results leave through an output register backed by a one-entry skid buffer.
// Reset (rst_n, synchronous, active low) empties the pipeline and loads the
//   register defaults: sizes 1, strides 0 except inner stride 1, base 0.
// ----------------------------------------------------------------------------
// strided_tensor_index_mapper_unit
// Maps a row-major linear index onto a strided storage index, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_tensor_index_mapper_unit #(
  parameter int unsigned MAX_RANK = 3
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  stim_in_if.sink                          in_ch,
  stim_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [stim_pkg::CFG_AW-1:0] paddr,
  input  wire logic [stim_pkg::CFG_DW-1:0] pwdata,
  output logic      [stim_pkg::CFG_DW-1:0] prdata,
  output logic                             pready
);
  import stim_pkg::*;

  stim_cfg_t         cfg;
  stim_dim_t         dim_q [MAX_RANK+1];
  logic              en;
  logic              out_valid_r;
  logic [SIDX_W-1:0] out_data_r;
  logic              skid_valid_r;
  logic [SIDX_W-1:0] skid_data_r;
  logic              pipe_vld;

  stim_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // pipeline advances while the skid buffer is empty
  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  assign dim_q[0] = '{vld: in_ch.valid, run: in_ch.linear_index,
                      acc: SIDX_W'(cfg.base_offset)};

  // dimensions from innermost outward
  for (genvar g = 0; g < MAX_RANK; g++) begin : g_dim
    logic [SIZE_W-1:0]   size;
    logic [STRIDE_W-1:0] stride;
    if (g == 0) begin : g_inner
      assign size   = cfg.size_inner;
      assign stride = cfg.stride_inner;
    end else if (g == 1) begin : g_middle
      assign size   = cfg.size_middle;
      assign stride = cfg.stride_middle;
    end else begin : g_outer
      assign size   = cfg.size_outer;
      assign stride = cfg.stride_outer;
    end
    stim_dim u_dim (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .size   (size),
      .stride (stride),
      .d_in   (dim_q[g]),
      .d_out  (dim_q[g+1])
    );
  end

  assign pipe_vld = dim_q[MAX_RANK].vld;

  // output register with skid buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_ch.ready) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (pipe_vld) begin
        out_data_r <= dim_q[MAX_RANK].acc;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (!out_valid_r) begin
      if (pipe_vld) begin
        out_valid_r <= 1'b1;
        out_data_r  <= dim_q[MAX_RANK].acc;
      end
    end else if (pipe_vld && en) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= dim_q[MAX_RANK].acc;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.storage_index = out_data_r;

  // skid entry only exists behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer full while output register empty");

  // draining the skid keeps the output register occupied
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ch.ready |=> out_valid_r && !skid_valid_r)
    else $error("skid buffer drain lost a transaction");

  // a stalled output with a result arriving fills the skid
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && pipe_vld && !skid_valid_r |=> skid_valid_r)
    else $error("pipeline result dropped under output stall");

endmodule

`default_nettype wire
